>>> src/abm_pkg.sv
// Package for the array bag multiset: sizes, request codes and beat types.
// Used by the sequencer and the top level; depends on nothing else.
package abm_pkg;

   localparam int DEPTH      = 64;
   localparam int ITEM_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] item_value;
   } req_beat_type;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] match_count;
      logic [CNT_W-1:0] size_now;
      logic             is_full;
      logic             is_empty;
   } rsp_beat_type;

endpackage

>>> src/array_bag_multiset.sv
// Top level of the array bag multiset: limit register, entry memory and
// sequencer. Depends on abm_pkg, abm_ram and abm_seq.
//
// A request beat is taken only while the sequencer is idle. Add and clear
// pass through the execute and result states into the output register;
// remove and query read the stored entries one per cycle through the
// single memory read port, and a remove that finds its match stops early
// and moves the last entry into the freed slot in a separate move state.
// A finished result waits in the output register while the next request
// is already taken. The limit register can be written at any time the
// block is idle; zero acts as one and values above the depth act as the
// depth.
module array_bag_multiset (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  abm_pkg::req_beat_type     req_beat,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output abm_pkg::rsp_beat_type     rsp_beat,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [abm_pkg::CNT_W-1:0] csr_wdata
);
   import abm_pkg::*;

   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      lim;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ITEM_WIDTH-1:0] ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ITEM_WIDTH-1:0] ram_rdata;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CNT_W'(64);
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      if (limit_ff == '0) begin
         lim = CNT_W'(1);
      end else if (limit_ff > CNT_W'(DEPTH)) begin
         lim = CNT_W'(DEPTH);
      end else begin
         lim = limit_ff;
      end
   end

   abm_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ITEM_WIDTH),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   abm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .lim       (lim),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

>>> src/abm_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stands alone; used by the top level to hold the stored entries.
module abm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/abm_seq.sv
// Sequencer of the bag: request decode, entry count, one-entry-per-cycle
// scan with a shared compare, remove compaction and the result register.
// Depends on abm_pkg; drives the ports of abm_ram.
module abm_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  abm_pkg::req_beat_type       req_beat,
   input  logic [abm_pkg::CNT_W-1:0]   lim,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output abm_pkg::rsp_beat_type       rsp_beat,
   output logic                        ram_we,
   output logic [abm_pkg::IDX_W-1:0]   ram_waddr,
   output logic [abm_pkg::ITEM_WIDTH-1:0] ram_wdata,
   output logic [abm_pkg::IDX_W-1:0]   ram_raddr,
   input  logic [abm_pkg::ITEM_WIDTH-1:0] ram_rdata
);
   import abm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_MOVE,
      ST_RESULT
   } state_type;

   state_type        state_ff, state_in;
   req_beat_type     req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             ok_ff, ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_ff, rsp_in;
   logic             hit;
   logic [CNT_W-1:0] last;

   assign hit  = cmp_vld_ff && (ram_rdata == req_ff.item_value[ITEM_WIDTH-1:0]);
   assign last = count_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      hits_in      = hits_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      match_idx_in = match_idx_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[IDX_W-1:0];
      ram_wdata    = req_ff.item_value[ITEM_WIDTH-1:0];
      ram_raddr    = issue_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_beat;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ok_in    = 1'b0;
            hits_in  = '0;
            issue_in = '0;
            unique case (op_type'(req_ff.req_type))
               OP_ADD: begin
                  if (count_ff < lim) begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     ok_in    = 1'b1;
                  end
                  state_in = ST_RESULT;
               end
               OP_REMOVE, OP_QUERY: begin
                  state_in = ST_SCAN;
               end
               OP_CLEAR: begin
                  count_in = '0;
                  ok_in    = 1'b1;
                  state_in = ST_RESULT;
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_SCAN: begin
            if (hit && (op_type'(req_ff.req_type) == OP_REMOVE)) begin
               ram_raddr    = last[IDX_W-1:0];
               match_idx_in = cmp_idx_ff;
               state_in     = ST_MOVE;
            end else begin
               if (hit) begin
                  hits_in = hits_ff + CNT_W'(1);
               end
               if (issue_ff < count_ff) begin
                  ram_raddr  = issue_ff[IDX_W-1:0];
                  cmp_vld_in = 1'b1;
                  cmp_idx_in = issue_ff[IDX_W-1:0];
                  issue_in   = issue_ff + CNT_W'(1);
               end else if (!cmp_vld_ff) begin
                  ok_in    = (op_type'(req_ff.req_type) == OP_QUERY) && (hits_ff != '0);
                  state_in = ST_RESULT;
               end
            end
         end
         ST_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = match_idx_ff;
            ram_wdata = ram_rdata;
            count_in  = last;
            ok_in     = 1'b1;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = ok_ff;
               rsp_in.match_count = (op_type'(req_ff.req_type) == OP_QUERY) ? hits_ff : '0;
               rsp_in.size_now    = count_ff;
               rsp_in.is_full     = (count_ff >= lim);
               rsp_in.is_empty    = (count_ff == '0);
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      issue_ff     <= issue_in;
      hits_ff      <= hits_in;
      cmp_idx_ff   <= cmp_idx_in;
      match_idx_ff <= match_idx_in;
      ok_ff        <= ok_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_EXEC) || (state_ff == ST_MOVE)))
      else $error("entry write outside add or compaction");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((issue_ff <= count_ff) && (hits_ff <= count_ff)))
      else $error("scan ran past stored entries");

   a_move_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not shrink the count");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for array_bag_multiset: directed and random request beats,
// checked against an in-bench model of the bag, limit register and result flags.
// Depends on abm_pkg and the array_bag_multiset RTL only.
module testbench;
   import abm_pkg::*;

   localparam int RUN_LIMIT = 300000;
   localparam int SETTLE    = 80;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_beat_type     req_beat;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_beat_type     rsp_beat;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_wdata;

   logic [ITEM_WIDTH-1:0] bag_store [DEPTH];
   logic [CNT_W-1:0]      bag_size;
   logic [CNT_W-1:0]      bag_limit;
   logic [ITEM_WIDTH-1:0] value_pool [8];
   rsp_beat_type          rsp_due [$];
   int                    bad_count = 0;
   int                    cycle_count = 0;
   int                    hold_cycles = 0;
   bit                    idling_on = 1'b1;

   array_bag_multiset i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("array_bag_multiset regression: fail");
         $finish;
      end
   end

   function automatic rsp_beat_type bag_apply(input op_type op, input logic [31:0] val);
      rsp_beat_type     r;
      logic [CNT_W-1:0] lim;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] tail;
      bit               done;
      int               i;
      if (bag_limit == 0)
         lim = CNT_W'(1);
      else if (bag_limit > DEPTH)
         lim = CNT_W'(DEPTH);
      else
         lim = bag_limit;
      r = '0;
      hits = '0;
      done = 1'b0;
      case (op)
         OP_ADD: begin
            if (bag_size < lim) begin
               bag_store[bag_size[IDX_W-1:0]] = val;
               bag_size = bag_size + CNT_W'(1);
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            for (i = 0; i < bag_size; i++) begin
               if (!done && bag_store[i[IDX_W-1:0]] == val) begin
                  tail = bag_size - CNT_W'(1);
                  bag_store[i[IDX_W-1:0]] = bag_store[tail[IDX_W-1:0]];
                  bag_size = tail;
                  r.ok = 1'b1;
                  done = 1'b1;
               end
            end
         end
         OP_QUERY: begin
            for (i = 0; i < bag_size; i++) begin
               if (bag_store[i[IDX_W-1:0]] == val)
                  hits = hits + CNT_W'(1);
            end
            r.ok = (hits != 0);
         end
         default: begin
            bag_size = '0;
            r.ok = 1'b1;
         end
      endcase
      r.match_count = hits;
      r.size_now    = bag_size;
      r.is_full     = (bag_size >= lim);
      r.is_empty    = (bag_size == 0);
      return r;
   endfunction

   // Sends one request beat; the expected result is queued at the accepting edge.
   task automatic issue_request(input op_type op, input logic [31:0] val);
      req_beat_type beat;
      beat.req_type   = op;
      beat.item_value = val;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= beat;
      do
         @(posedge clock);
      while (req_stall);
      rsp_due = {rsp_due, bag_apply(op, val)};
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (rsp_due.size() != 0);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      bag_limit = value;
   endtask

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 65)
         return value_pool[$urandom_range(0, 7)];
      else if (sel < 72)
         return 32'h0000_0000;
      else if (sel < 79)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic run_phase(input int count, input logic [CNT_W-1:0] limit, input int add_w);
      int sel;
      write_limit(limit);
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < add_w)
            issue_request(OP_ADD, pick_value());
         else if (sel >= 97)
            issue_request(OP_CLEAR, pick_value());
         else if ($urandom_range(0, 1) == 0)
            issue_request(OP_REMOVE, pick_value());
         else
            issue_request(OP_QUERY, pick_value());
      end
   endtask

   task automatic test_empty_bag;
      issue_request(OP_QUERY, 32'h0000_0000);
      issue_request(OP_REMOVE, 32'hFFFF_FFFF);
   endtask

   task automatic test_basic_ops;
      issue_request(OP_ADD, 32'h0000_0000);
      issue_request(OP_ADD, 32'hFFFF_FFFF);
      issue_request(OP_ADD, 32'hFFFF_FFFF);
      issue_request(OP_ADD, 32'hA5A5_5A5A);
      issue_request(OP_QUERY, 32'hFFFF_FFFF);
      issue_request(OP_QUERY, 32'h0000_0000);
      issue_request(OP_QUERY, 32'h1234_5678);
      issue_request(OP_REMOVE, 32'hFFFF_FFFF);
      issue_request(OP_REMOVE, 32'h0000_0000);
      issue_request(OP_REMOVE, 32'h0000_0077);
      issue_request(OP_QUERY, 32'hFFFF_FFFF);
      issue_request(OP_CLEAR, 32'h5A5A_A5A5);
      issue_request(OP_QUERY, 32'hA5A5_5A5A);
   endtask

   // A limit of zero behaves as one, values past the depth as the depth, and
   // lowering the limit under the current size keeps the stored items.
   task automatic test_limit_corners;
      write_limit(7'd1);
      issue_request(OP_ADD, 32'h0000_0001);
      issue_request(OP_ADD, 32'h0000_0002);
      write_limit(7'd0);
      issue_request(OP_ADD, 32'h0000_0003);
      write_limit(7'd127);
      issue_request(OP_ADD, 32'h0000_0004);
      write_limit(7'd3);
      issue_request(OP_ADD, 32'h0000_0005);
      write_limit(7'd2);
      issue_request(OP_ADD, 32'h0000_0006);
      issue_request(OP_CLEAR, 32'h0000_0000);
   endtask

   task automatic test_backpressure;
      write_limit(7'd64);
      hold_cycles = 200;
      repeat (8) issue_request(OP_ADD, pick_value());
      issue_request(OP_QUERY, value_pool[0]);
      drain();
   endtask

   task automatic test_random_mix;
      run_phase(90, 7'd64, 85);
      run_phase(40, 7'd5, 40);
      run_phase(30, 7'd0, 50);
      run_phase(60, 7'd127, 60);
      repeat (4) run_phase(50, CNT_W'($urandom_range(0, 127)), 55);
      idling_on = 1'b0;
      run_phase(80, CNT_W'($urandom_range(1, 64)), 55);
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected result beat: ok=%0d count=%0d size=%0d full=%0d empty=%0d",
                        rsp_beat.ok, rsp_beat.match_count, rsp_beat.size_now,
                        rsp_beat.is_full, rsp_beat.is_empty);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_beat.ok !== want.ok || rsp_beat.match_count !== want.match_count ||
                rsp_beat.size_now !== want.size_now || rsp_beat.is_full !== want.is_full ||
                rsp_beat.is_empty !== want.is_empty) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("mismatch: expected ok=%0d count=%0d size=%0d full=%0d empty=%0d, %s",
                           want.ok, want.match_count, want.size_now, want.is_full,
                           want.is_empty,
                           $sformatf("got ok=%0d count=%0d size=%0d full=%0d empty=%0d",
                                     rsp_beat.ok, rsp_beat.match_count, rsp_beat.size_now,
                                     rsp_beat.is_full, rsp_beat.is_empty));
            end
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_beat  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      bag_size  = '0;
      bag_limit = 7'd64;
      foreach (value_pool[k])
         value_pool[k] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_bag();
      test_basic_ops();
      test_limit_corners();
      test_backpressure();
      test_random_mix();

      drain();
      repeat (SETTLE) @(posedge clock);
      bad_count += rsp_due.size();
      if (bad_count == 0)
         $display("array_bag_multiset regression: pass");
      else
         $display("array_bag_multiset regression: fail");
      $finish;
   end

endmodule
